// ----- hw/rtl/ipv4_fwd_pkg.sv -----
package ipv4_fwd_pkg;

  // Route table geometry
  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  // Commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_HDR   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Verdicts
  localparam logic [2:0] V_LOCAL   = 3'd0;
  localparam logic [2:0] V_FORWARD = 3'd1;
  localparam logic [2:0] V_TTL     = 3'd2;
  localparam logic [2:0] V_NOROUTE = 3'd3;
  localparam logic [2:0] V_ADDED   = 3'd4;
  localparam logic [2:0] V_FULL    = 3'd5;
  localparam logic [2:0] V_CLEARED = 3'd6;

  localparam logic [5:0] MAX_LEN = 6'd32;
  localparam logic [3:0] MIN_IHL = 4'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] route_dest;
    logic [5:0]  route_mask_len;
    logic [31:0] route_next_hop;
    logic [15:0] header_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } rsp_t;

  // Prefix mask for a length of 0..32
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    prefix_mask = ~(32'hffffffff >> len);
  endfunction

  // Ones'-complement 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    ones_add = s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- hw/rtl/ipv4_forward_decision_top.sv -----
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_stall  req_t: command, route fields, header word
// rsp      out  rsp_valid / rsp_stall  rsp_t: verdict, next hop, TTL, checksum
// cfg      in   cfg_valid / cfg_ready  local address (32 bits)
//
// An add passes one route entry per cycle through the
// shared prefix compare unit, then writes the table.
// After the last header word, a local or TTL verdict is given from the decision step;
// otherwise the longest-prefix scan runs.
// Reset (rst, synchronous) clears the valid bits, parser state and local address.
// req_stall is high while a command is in progress and while a result waits in rsp.
module ipv4_forward_decision_top
  import ipv4_fwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;

  // Route table
  logic [31:0] route_prefix [ROUTE_ENTRIES];
  logic [5:0]  route_length [ROUTE_ENTRIES];
  logic [31:0] route_hop    [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0] route_valid;

  // Header parser state
  logic [4:0]  word_index;
  logic [3:0]  header_length;
  logic [7:0]  ttl_seen;
  logic [31:0] dest_seen;
  logic [15:0] sum_acc;
  logic [31:0] local_address;

  // Scan state
  logic             is_add;
  logic [31:0]      key;
  logic [5:0]       key_len;
  logic [31:0]      key_hop;
  logic [IDX_W-1:0] rd_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic [31:0]      rd_prefix;
  logic [5:0]       rd_len;
  logic [31:0]      rd_hop;
  logic             rd_vbit;
  logic             match_found;
  logic [IDX_W-1:0] match_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             best_found;
  logic [5:0]       best_len;
  logic [31:0]      best_hop;

  logic req_acc;
  logic out_free;
  logic emit;
  rsp_t rsp_next;
  logic hit;
  logic len_eq;

  // Header word datapath
  logic [15:0] hdr_word;
  logic [3:0]  hdr_len_new;
  logic [3:0]  hdr_len_cur;
  logic [15:0] hdr_sum_base;
  logic [15:0] hdr_sum;
  logic        hdr_last;
  logic [5:0]  add_len;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign req_acc   = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  // Saturate the route length
  assign add_len = (req.route_mask_len > MAX_LEN) ? MAX_LEN : req.route_mask_len;

  // Parse one header word
  always_comb begin
    hdr_word = req.header_word;
    if (word_index == 5'd4) begin
      hdr_word = {req.header_word[15:8] - 8'd1, req.header_word[7:0]};
    end
    hdr_len_new  = (req.header_word[11:8] < MIN_IHL) ? MIN_IHL : req.header_word[11:8];
    hdr_len_cur  = (word_index == 5'd0) ? hdr_len_new : header_length;
    hdr_sum_base = (word_index == 5'd0) ? 16'd0 : sum_acc;
    hdr_sum      = (word_index == 5'd5) ? hdr_sum_base : ones_add(hdr_sum_base, hdr_word);
    hdr_last     = ({1'b0, word_index} + 6'd1) >= {1'b0, hdr_len_cur, 1'b0};
  end

  // Shared prefix compare unit
  assign hit    = rd_vbit && ((key & prefix_mask(rd_len)) == rd_prefix);
  assign len_eq = (rd_len == key_len);

  // Select the result to emit
  always_comb begin
    emit     = 1'b0;
    rsp_next = '0;
    case (state)
      S_IDLE: begin
        if (req_acc && req.cmd == CMD_CLEAR) begin
          emit             = 1'b1;
          rsp_next.verdict = V_CLEARED;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          if (dest_seen == local_address) begin
            emit             = 1'b1;
            rsp_next.verdict = V_LOCAL;
          end else if (ttl_seen == 8'd0) begin
            emit             = 1'b1;
            rsp_next.verdict = V_TTL;
          end
        end
      end
      S_FINISH: begin
        if (!cmp_vld && out_free) begin
          emit = 1'b1;
          if (is_add) begin
            rsp_next.verdict = (match_found || free_found) ? V_ADDED : V_FULL;
          end else if (best_found) begin
            rsp_next.verdict      = V_FORWARD;
            rsp_next.next_hop     = best_hop;
            rsp_next.new_ttl      = ttl_seen - 8'd1;
            rsp_next.new_checksum = ~sum_acc;
          end else begin
            rsp_next.verdict = V_NOROUTE;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      route_valid   <= '0;
      word_index    <= 5'd0;
      header_length <= 4'd0;
      ttl_seen      <= 8'd0;
      dest_seen     <= 32'd0;
      sum_acc       <= 16'd0;
      local_address <= 32'd0;
      rsp_valid     <= 1'b0;
      cmp_vld       <= 1'b0;
      rd_idx        <= '0;
      is_add        <= 1'b0;
      match_found   <= 1'b0;
      free_found    <= 1'b0;
      best_found    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        local_address <= cfg_data;
      end

      // Drain or load the result register
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      cmp_vld <= (state == S_SCAN);

      // Record compare outcomes
      if (cmp_vld) begin
        if (is_add) begin
          if (hit && len_eq && !match_found) begin
            match_found <= 1'b1;
          end
          if (!rd_vbit && !free_found) begin
            free_found <= 1'b1;
          end
        end else if (hit && (!best_found || rd_len > best_len)) begin
          best_found <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            case (req.cmd)
              CMD_ADD: begin
                is_add      <= 1'b1;
                match_found <= 1'b0;
                free_found  <= 1'b0;
                rd_idx      <= '0;
                state       <= S_SCAN;
              end
              CMD_HDR: begin
                if (word_index == 5'd0) begin
                  header_length <= hdr_len_new;
                end
                if (word_index == 5'd4) begin
                  ttl_seen <= req.header_word[15:8];
                end
                if (word_index == 5'd8) begin
                  dest_seen[31:16] <= req.header_word;
                end
                if (word_index == 5'd9) begin
                  dest_seen[15:0] <= req.header_word;
                end
                sum_acc <= hdr_sum;
                if (hdr_last) begin
                  word_index <= 5'd0;
                  state      <= S_DECIDE;
                end else begin
                  word_index <= word_index + 5'd1;
                end
              end
              CMD_CLEAR: begin
                route_valid <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DECIDE: begin
          if (dest_seen != local_address && ttl_seen != 8'd0) begin
            is_add     <= 1'b0;
            best_found <= 1'b0;
            rd_idx     <= '0;
            state      <= S_SCAN;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + IDX_W'(1);
          if (rd_idx == LAST_IDX) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (emit) begin
            if (is_add && !match_found && free_found) begin
              route_valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Route table read port and payload registers
  always_ff @(posedge clk) begin
    rd_prefix <= route_prefix[rd_idx];
    rd_len    <= route_length[rd_idx];
    rd_hop    <= route_hop[rd_idx];
    rd_vbit   <= route_valid[rd_idx];
    cmp_idx   <= rd_idx;

    if (state == S_IDLE && req_acc && req.cmd == CMD_ADD) begin
      key     <= req.route_dest & prefix_mask(add_len);
      key_len <= add_len;
      key_hop <= req.route_next_hop;
    end else if (state == S_DECIDE) begin
      key <= dest_seen;
    end

    if (cmp_vld) begin
      if (is_add) begin
        if (hit && len_eq && !match_found) begin
          match_idx <= cmp_idx;
        end
        if (!rd_vbit && !free_found) begin
          free_idx <= cmp_idx;
        end
      end else if (hit && (!best_found || rd_len > best_len)) begin
        best_len <= rd_len;
        best_hop <= rd_hop;
      end
    end

    // Write the route table at the end of an add
    if (state == S_FINISH && emit && is_add) begin
      if (match_found) begin
        route_hop[match_idx] <= key_hop;
      end else if (free_found) begin
        route_prefix[free_idx] <= key;
        route_length[free_idx] <= key_len;
        route_hop[free_idx]    <= key_hop;
      end
    end

    if (emit) begin
      rsp <= rsp_next;
    end
  end

  // A final header word moves the sequencer to the decision step
  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == CMD_HDR && hdr_last) |=> (state == S_DECIDE))
    else $error("final header word did not start a decision");

  // Word index never runs past a 30-word header
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    word_index <= 5'd29)
    else $error("header word index out of range");

  // A clear empties the table and reports at once
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == CMD_CLEAR) |=>
      (route_valid == '0 && rsp_valid && rsp.verdict == V_CLEARED))
    else $error("clear did not empty the table");

  // A forward never carries a TTL that wrapped from zero
  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.verdict == V_FORWARD) |-> (rsp.new_ttl != 8'hff))
    else $error("forward with zero TTL");

endmodule

// ----- tb/sv/ipv4_forward_decision_top_tb.sv -----
`timescale 1ns / 1ps

module ipv4_forward_decision_top_tb;
  import ipv4_fwd_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = ROUTE_ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1240;
  localparam int BOOK_DEPTH = 32;
  localparam int IDLE_PCT = 24;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Header word positions the parser cares about
  localparam int W_LEN = 0;
  localparam int W_TTL = 4;
  localparam int W_CSUM = 5;
  localparam int W_DST_HI = 8;
  localparam int W_DST_LO = 9;

  typedef struct {
    logic [31:0] dest;
    logic [5:0]  len;
  } route_note_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Mirror of the route table, the header parser and the local address
  logic [31:0] tbl_pfx [ROUTE_ENTRIES];
  logic [5:0]  tbl_len [ROUTE_ENTRIES];
  logic [31:0] tbl_hop [ROUTE_ENTRIES];
  logic        tbl_vld [ROUTE_ENTRIES] = '{default: 1'b0};
  int          word_idx = 0;
  int          hdr_len = 0;
  logic [7:0]  ttl_seen = '0;
  logic [31:0] dest_seen = '0;
  logic [15:0] ck_sum = '0;
  logic [31:0] local_addr = '0;

  rsp_t        pending_verdicts [$];
  route_note_t route_book [$];
  int          verdict_tally [8] = '{default: 0};
  int          items_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  ipv4_forward_decision_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    rsp_stall <= !rst && idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic logic [5:0] sat_len(input logic [5:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [31:0] mask_for(input logic [5:0] len);
    if (len == 0) return '0;
    return 32'hffff_ffff << (32 - int'(sat_len(len)));
  endfunction

  function automatic logic [15:0] ones_sum(input logic [15:0] acc, input logic [15:0] addend);
    logic [31:0] s;
    s = 32'(acc) + 32'(addend);
    return 16'((s & 32'hffff) + (s >> 16));
  endfunction

  // Advance the mirror by one accepted item and queue the verdict it causes
  task automatic compute_verdict(input req_t item);
    rsp_t        res;
    logic [15:0] w;
    logic [5:0]  len;
    logic [31:0] pfx;
    int          slot;
    int          best;
    bit          has_res;
    res = '0;
    has_res = 1'b0;
    slot = -1;
    best = -1;
    case (item.cmd)
      CMD_ADD: begin
        len = sat_len(item.route_mask_len);
        pfx = item.route_dest & mask_for(len);
        // reuse a matching route, else take the first free slot
        for (int i = 0; i < ROUTE_ENTRIES; i++)
          if (slot < 0 && tbl_vld[i] && tbl_pfx[i] == pfx && tbl_len[i] == len) slot = i;
        for (int i = 0; i < ROUTE_ENTRIES; i++)
          if (slot < 0 && !tbl_vld[i]) begin
            slot = i;
            tbl_vld[i] = 1'b1;
            tbl_pfx[i] = pfx;
            tbl_len[i] = len;
          end
        if (slot < 0) begin
          res.verdict = V_FULL;
        end else begin
          tbl_hop[slot] = item.route_next_hop;
          res.verdict = V_ADDED;
        end
        has_res = 1'b1;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ROUTE_ENTRIES; i++) tbl_vld[i] = 1'b0;
        res.verdict = V_CLEARED;
        has_res = 1'b1;
      end
      CMD_HDR: begin
        w = item.header_word;
        if (word_idx == W_LEN) begin
          hdr_len = (w[11:8] < MIN_IHL) ? int'(MIN_IHL) : int'(w[11:8]);
          ck_sum = '0;
        end
        // checksum covers the header with TTL already decremented
        if (word_idx == W_TTL) begin
          ttl_seen = w[15:8];
          w[15:8] = w[15:8] - 8'd1;
        end
        if (word_idx == W_DST_HI) dest_seen[31:16] = w;
        if (word_idx == W_DST_LO) dest_seen[15:0] = w;
        if (word_idx != W_CSUM) ck_sum = ones_sum(ck_sum, w);
        if (word_idx + 1 < hdr_len * 2) begin
          word_idx++;
        end else begin
          word_idx = 0;
          has_res = 1'b1;
          if (dest_seen == local_addr) begin
            res.verdict = V_LOCAL;
          end else if (ttl_seen == 0) begin
            res.verdict = V_TTL;
          end else begin
            // longest prefix wins, lowest slot on a tie
            for (int i = 0; i < ROUTE_ENTRIES; i++)
              if (tbl_vld[i] && (dest_seen & mask_for(tbl_len[i])) == tbl_pfx[i] &&
                  (best < 0 || tbl_len[i] > tbl_len[best])) best = i;
            if (best < 0) begin
              res.verdict = V_NOROUTE;
            end else begin
              res.verdict = V_FORWARD;
              res.next_hop = tbl_hop[best];
              res.new_ttl = ttl_seen - 8'd1;
              res.new_checksum = ~ck_sum;
            end
          end
        end
      end
      default: ;
    endcase
    if (has_res) begin
      pending_verdicts.push_back(res);
      verdict_tally[res.verdict]++;
    end
  endtask

  task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
    if (mismatches < 10)
      $display("mismatch (%s) at %0t: want verdict %0d hop %h ttl %0d sum %h, %s %0d %h %0d %h",
               what, $time, want.verdict, want.next_hop, want.new_ttl, want.new_checksum,
               "got", got.verdict, got.next_hop, got.new_ttl, got.new_checksum);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest queued verdict
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("no item waiting", '0, rsp);
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp.verdict !== want.verdict || rsp.next_hop !== want.next_hop ||
            rsp.new_ttl !== want.new_ttl || rsp.new_checksum !== want.new_checksum)
          report_mismatch("wrong field", want, rsp);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d verdicts outstanding",
               quiet_cycles, pending_verdicts.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t rand_fields(input logic [1:0] cmd);
    req_t r;
    r.cmd = cmd;
    r.route_dest = $urandom;
    r.route_mask_len = 6'($urandom);
    r.route_next_hop = $urandom;
    r.header_word = 16'($urandom);
    return r;
  endfunction

  // Present one item, hold it until accepted, then maybe idle
  task automatic send_item(input req_t item);
    int gap;
    gap = 0;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    compute_verdict(item);
    if (item.cmd != CMD_UNUSED) items_sent++;
    if (idle_on) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every verdict is back and the block has settled
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_local(input logic [31:0] addr);
    drain();
    cfg_data <= addr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    local_addr = addr;
  endtask

  task automatic add_route(input logic [31:0] dest, input logic [5:0] len,
                           input logic [31:0] hop);
    req_t r;
    r = rand_fields(CMD_ADD);
    r.route_dest = dest;
    r.route_mask_len = len;
    r.route_next_hop = hop;
    send_item(r);
  endtask

  task automatic clear_table();
    send_item(rand_fields(CMD_CLEAR));
  endtask

  // Send one whole header; optionally slip another command in after word mid_at
  task automatic send_header(input logic [3:0] ihl, input logic [7:0] ttl,
                             input logic [31:0] dest, input int mid_at, input req_t mid_item);
    req_t r;
    int   n;
    // finish any header left open by stray words
    while (word_idx != 0) send_item(rand_fields(CMD_HDR));
    n = ((ihl < MIN_IHL) ? int'(MIN_IHL) : int'(ihl)) * 2;
    for (int k = 0; k < n; k++) begin
      r = rand_fields(CMD_HDR);
      case (k)
        W_LEN:    r.header_word[11:8] = ihl;
        W_TTL:    r.header_word[15:8] = ttl;
        W_DST_HI: r.header_word = dest[31:16];
        W_DST_LO: r.header_word = dest[15:0];
        default: ;
      endcase
      send_item(r);
      if (k == mid_at) send_item(mid_item);
    end
  endtask

  function automatic logic [3:0] pick_ihl();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 4'd5;
    if (r < 80) return 4'($urandom_range(4));
    return 4'($urandom_range(15, 6));
  endfunction

  function automatic logic [7:0] pick_ttl();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd1;
    if (r < 25) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 6'd0;
    if (r < 27) return 6'd32;
    if (r < 37) return 6'($urandom_range(63, 33));
    return 6'($urandom_range(31, 1));
  endfunction

  // Aim destinations at known routes, the local address, or anywhere
  function automatic logic [31:0] pick_dest();
    int          r;
    route_note_t n;
    logic [31:0] m;
    r = $urandom_range(99);
    if (r < 10) return local_addr;
    if (r < 25 || route_book.size() == 0) return $urandom;
    n = route_book[$urandom_range(route_book.size() - 1)];
    m = mask_for(n.len);
    return (n.dest & m) | ($urandom & ~m);
  endfunction

  function automatic req_t side_item();
    int r;
    r = $urandom_range(99);
    if (r < 50) return rand_fields(CMD_ADD);
    if (r < 75) return rand_fields(CMD_CLEAR);
    return rand_fields(CMD_UNUSED);
  endfunction

  // Add a route: overwrite a known one, nest under one, or pick a fresh one
  task automatic random_add();
    route_note_t base;
    route_note_t note;
    int          r;
    r = $urandom_range(99);
    if (route_book.size() > 0) base = route_book[$urandom_range(route_book.size() - 1)];
    if (r < 10 && route_book.size() > 0) begin
      note = base;
    end else if (r < 50 && route_book.size() > 0) begin
      note.len = sat_len(base.len) + 6'($urandom_range(8, 1));
      note.dest = (base.dest & mask_for(base.len)) | ($urandom & ~mask_for(base.len));
    end else begin
      note.dest = $urandom;
      note.len = pick_len();
    end
    add_route(note.dest, note.len, $urandom);
    route_book.push_back(note);
    if (route_book.size() > BOOK_DEPTH) route_book.delete(0);
  endtask

  task automatic random_step();
    int r;
    int mid_at;
    r = $urandom_range(99);
    mid_at = ($urandom_range(9) == 0) ? int'($urandom_range(8)) : -1;
    if (r < 68) begin
      send_header(pick_ihl(), pick_ttl(), pick_dest(), mid_at, side_item());
    end else if (r < 88) begin
      random_add();
    end else if (r < 91) begin
      clear_table();
    end else if (r < 95) begin
      send_item(rand_fields(CMD_UNUSED));
    end else begin
      // broken header: a few stray words, completed before the next header
      repeat ($urandom_range(8, 1)) send_item(rand_fields(CMD_HDR));
    end
  endtask

  task automatic test_route_commands();
    clear_table();
    add_route(32'hc0a8_01ff, 6'd24, 32'h0a0a_0001);
    add_route(32'hc0a8_0123, 6'd24, 32'h0a0a_0002);
    add_route(32'hffff_ffff, 6'd0, 32'h0a0a_00ff);
    add_route(32'hc0a8_0107, 6'd63, 32'h0a0a_0003);
    add_route(32'hc0a8_0107, 6'd32, 32'h0a0a_0004);
    send_item(rand_fields(CMD_UNUSED));
  endtask

  task automatic test_header_verdicts();
    req_t mid;
    write_local(32'h0a00_0001);
    // local delivery takes precedence over a zero TTL
    send_header(4'd5, 8'd0, 32'h0a00_0001, -1, '0);
    send_header(4'd5, 8'd0, 32'hc0a8_0107, -1, '0);
    send_header(4'd5, 8'd1, 32'hc0a8_0107, -1, '0);
    send_header(4'd0, 8'hff, 32'hc0a8_0155, -1, '0);
    // add a /16 in the middle of a long header; it must win over the default
    mid = rand_fields(CMD_ADD);
    mid.route_dest = 32'h0808_1234;
    mid.route_mask_len = 6'd16;
    send_header(4'd15, 8'd64, 32'h0808_0808, 3, mid);
    // clear in the middle of a header leaves no route
    send_header(4'd6, 8'd64, 32'h0808_0808, 7, rand_fields(CMD_CLEAR));
  endtask

  task automatic test_table_full();
    clear_table();
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      add_route({8'(i + 1), 24'h5a_5a5a}, 6'd8, $urandom);
    add_route(32'haa00_0000, 6'd8, 32'h0bad_0001);
    add_route(32'h0300_0000, 6'd8, 32'h0c0f_fee0);
    send_header(4'd5, 8'd9, 32'h0312_3456, -1, '0);
    send_header(4'd5, 8'd9, 32'haa12_3456, -1, '0);
  endtask

  task automatic test_local_settings();
    write_local(32'h0000_0000);
    send_header(4'd5, 8'd1, 32'h0000_0000, -1, '0);
    write_local(32'hffff_ffff);
    send_header(4'd5, 8'd0, 32'hffff_ffff, -1, '0);
    send_header(4'd5, 8'd64, 32'h0000_0000, -1, '0);
  endtask

  // Random traffic in four phases, each with its own local address
  task automatic test_random_traffic();
    int          goal;
    int          quarter;
    logic [31:0] addr;
    goal = items_sent + RANDOM_ITEMS;
    quarter = RANDOM_ITEMS / 4;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: addr = $urandom;
        1: addr = '0;
        2: addr = '1;
        default: addr = pick_dest();
      endcase
      write_local(addr);
      // no idling on either side during the second phase
      idle_on = (phase != 1);
      while (items_sent < goal - (3 - phase) * quarter) random_step();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_route_commands();
    test_header_verdicts();
    test_table_full();
    test_local_settings();
    test_random_traffic();
    drain();
    $display("covered %0d items, %0d results: %0d forwarded, %0d local, %0d TTL discards,",
             items_sent, results_seen, verdict_tally[V_FORWARD], verdict_tally[V_LOCAL],
             verdict_tally[V_TTL]);
    $display("  %0d without route, %0d routes added, %0d refused as full, %0d table clears",
             verdict_tally[V_NOROUTE], verdict_tally[V_ADDED], verdict_tally[V_FULL],
             verdict_tally[V_CLEARED]);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ipv4_fwd_pkg.sv
hw/rtl/ipv4_forward_decision_top.sv
tb/sv/ipv4_forward_decision_top_tb.sv
